@@ hdl/ptti_pkg.sv @@
package ptti_pkg;

  // Table geometry
  localparam int MAX_FRAMES = 1024;
  localparam int ADDR_W     = $clog2(MAX_FRAMES);
  localparam int CNT_W      = ADDR_W + 1;

  // Field widths
  localparam int FUNC_W = 2;
  localparam int PROG_W = 23;
  localparam int TIME_W = 32;

  // Interpolation datapath widths
  localparam int PROD_W = PROG_W + TIME_W;
  localparam int DVD_W  = PROD_W + 1;
  localparam int QCNT_W = $clog2(DVD_W);

  // Function codes on the request channel
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  // Minimum progress span for a usable table (0.001 percent)
  localparam logic [PROG_W:0] SPAN_MIN = (PROG_W + 1)'(65);
  // One second in Q16
  localparam logic [TIME_W:0] ONE_SECOND = (TIME_W + 1)'(65536);

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_QUERY,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [PROG_W-1:0] progress;
    logic [TIME_W-1:0] time_value;
  } item_t;

endpackage

@@ hdl/ptti_req_if.sv @@
interface ptti_req_if import ptti_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [PROG_W-1:0] progress;
  logic [TIME_W-1:0] time_value;

  modport source (output valid, func, progress, time_value, input ready);
  modport sink (input valid, func, progress, time_value, output ready);
endinterface

@@ hdl/ptti_rsp_if.sv @@
interface ptti_rsp_if import ptti_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] result_time;
  logic              used_fallback;
  logic              alignment_ok;
  logic              dropped;

  modport source (output valid, result_time, used_fallback, alignment_ok, dropped,
                  input ready);
  modport sink (input valid, result_time, used_fallback, alignment_ok, dropped,
                output ready);
endinterface

@@ hdl/ptti_ram.sv @@
module ptti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/ptti_front.sv @@
module ptti_front import ptti_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  ptti_req_if.sink req_i,
  output logic  q_valid_o,
  output item_t q_item_o,
  input  logic  q_ready_i
);

  item_t       fifo_q [2];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        push;
  logic        pop;
  op_e         op;

  // Decode the function code into an operation class.
  always_comb begin
    unique case (req_i.func)
      FUNC_CLEAR:  op = OP_CLEAR;
      FUNC_APPEND: op = OP_APPEND;
      FUNC_QUERY:  op = OP_QUERY;
      default:     op = OP_NONE;
    endcase
  end

  assign req_i.ready = (cnt_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;
  assign q_valid_o   = (cnt_q != 2'd0);
  assign q_item_o    = fifo_q[rd_ptr_q];
  assign pop         = q_valid_o && q_ready_i;

  // Two-entry queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{op: op, progress: req_i.progress, time_value: req_i.time_value};
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

@@ hdl/ptti_div.sv @@
module ptti_div import ptti_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DVD_W-1:0]  dividend_i,
  input  logic [PROG_W-1:0] divisor_i,
  output logic              done_o,
  output logic [TIME_W-1:0] quotient_o
);

  logic [DVD_W-1:0]  work_q;
  logic [PROG_W-1:0] rem_q;
  logic [PROG_W-1:0] div_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [PROG_W:0]   rem_sh;
  logic              ge;
  logic [PROG_W:0]   rem_sub;

  // One restoring step: bring in the next dividend bit and try a subtract.
  assign rem_sh  = {rem_q, work_q[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, div_q};
  assign rem_sub = rem_sh - {1'b0, div_q};

  assign done_o     = done_q;
  assign quotient_o = work_q[TIME_W-1:0];

  // Operand and partial remainder registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      work_q <= {work_q[DVD_W-2:0], ge};
      rem_q  <= ge ? rem_sub[PROG_W-1:0] : rem_sh[PROG_W-1:0];
    end
  end

  // Step counter and completion flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == QCNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + QCNT_W'(1);
      end
    end
  end

endmodule

@@ hdl/ptti_back.sv @@
module ptti_back import ptti_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  q_valid_i,
  input  item_t q_item_i,
  output logic  q_ready_o,
  ptti_rsp_if.source rsp_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_RDLO,
    ST_CALC,
    ST_MUL,
    ST_DIV,
    ST_WAIT
  } state_e;

  state_e state_q, state_d;

  // Table bookkeeping
  logic [CNT_W-1:0]  count_q, count_d;
  logic              order_q, order_d;
  logic [PROG_W-1:0] first_prog_q, first_prog_d;
  logic [TIME_W-1:0] first_time_q, first_time_d;
  logic [PROG_W-1:0] last_prog_q, last_prog_d;
  logic [TIME_W-1:0] last_time_q, last_time_d;

  // Query working registers
  logic [PROG_W-1:0] p_q, p_d;
  logic [CNT_W-1:0]  lo_q, lo_d;
  logic [CNT_W-1:0]  len_q, len_d;
  logic [CNT_W-1:0]  mid_q, mid_d;
  logic [PROG_W-1:0] prog_hi_q, prog_hi_d;
  logic [TIME_W-1:0] time_hi_q, time_hi_d;
  logic [TIME_W-1:0] t0_q, t0_d;
  logic              up_q, up_d;
  logic [TIME_W-1:0] mag_q, mag_d;
  logic [PROG_W-1:0] num_q, num_d;
  logic [PROG_W-1:0] delta_q, delta_d;
  logic [PROD_W-1:0] prod_q, prod_d;

  // Result register
  logic              rsp_valid_q, rsp_valid_d;
  logic [TIME_W-1:0] res_time_q, res_time_d;
  logic              res_fb_q, res_fb_d;
  logic              res_align_q, res_align_d;
  logic              res_drop_q, res_drop_d;

  // Memory ports
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [PROG_W-1:0] prog_rdata;
  logic [TIME_W-1:0] time_rdata;

  // Divider
  logic              div_start;
  logic [DVD_W-1:0]  div_dividend;
  logic              div_done;
  logic [TIME_W-1:0] div_quot;

  logic              rsp_free;
  logic              full;
  logic [CNT_W-1:0]  half;
  logic [CNT_W-1:0]  mid;
  logic [TIME_W:0]   last_plus;

  // Table is fit for alignment: at least two entries, ordered, and a real span.
  function automatic logic align_ok(logic [CNT_W-1:0] cnt, logic ord,
                                    logic [PROG_W-1:0] first, logic [PROG_W-1:0] last);
    logic [PROG_W:0] lim;
    lim = {1'b0, first} + SPAN_MIN;
    return (cnt >= CNT_W'(2)) && ord && ({1'b0, last} > lim);
  endfunction

  ptti_ram #(.WIDTH(PROG_W), .DEPTH(MAX_FRAMES)) u_prog_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (q_item_i.progress),
    .raddr_i (raddr),
    .rdata_o (prog_rdata)
  );

  ptti_ram #(.WIDTH(TIME_W), .DEPTH(MAX_FRAMES)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (q_item_i.time_value),
    .raddr_i (raddr),
    .rdata_o (time_rdata)
  );

  ptti_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (delta_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign rsp_free          = !rsp_valid_q || rsp_o.ready;
  assign full              = (count_q == CNT_W'(MAX_FRAMES));
  assign half              = len_q >> 1;
  assign mid               = lo_q + half;
  assign last_plus         = {1'b0, last_time_q} + ONE_SECOND;
  assign waddr             = count_q[ADDR_W-1:0];
  assign div_dividend      = {1'b0, prod_q} + DVD_W'(delta_q >> 1);

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.result_time   = res_time_q;
  assign rsp_o.used_fallback = res_fb_q;
  assign rsp_o.alignment_ok  = res_align_q;
  assign rsp_o.dropped       = res_drop_q;

  // Sequencer: fast ops end on pop, in-range queries search and interpolate.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    order_d      = order_q;
    first_prog_d = first_prog_q;
    first_time_d = first_time_q;
    last_prog_d  = last_prog_q;
    last_time_d  = last_time_q;
    p_d          = p_q;
    lo_d         = lo_q;
    len_d        = len_q;
    mid_d        = mid_q;
    prog_hi_d    = prog_hi_q;
    time_hi_d    = time_hi_q;
    t0_d         = t0_q;
    up_d         = up_q;
    mag_d        = mag_q;
    num_d        = num_q;
    delta_d      = delta_q;
    prod_d       = prod_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    res_time_d   = res_time_q;
    res_fb_d     = res_fb_q;
    res_align_d  = res_align_q;
    res_drop_d   = res_drop_q;
    q_ready_o    = 1'b0;
    we           = 1'b0;
    raddr        = mid[ADDR_W-1:0];
    div_start    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && rsp_free) begin
          q_ready_o   = 1'b1;
          rsp_valid_d = 1'b1;
          res_time_d  = '0;
          res_fb_d    = 1'b0;
          res_drop_d  = 1'b0;
          res_align_d = align_ok(count_q, order_q, first_prog_q, last_prog_q);
          unique case (q_item_i.op)
            OP_CLEAR: begin
              count_d     = '0;
              order_d     = 1'b1;
              res_align_d = 1'b0;
            end
            OP_APPEND: begin
              if (full) begin
                res_drop_d = 1'b1;
              end else begin
                we          = 1'b1;
                count_d     = count_q + CNT_W'(1);
                last_prog_d = q_item_i.progress;
                last_time_d = q_item_i.time_value;
                if (count_q == '0) begin
                  first_prog_d = q_item_i.progress;
                  first_time_d = q_item_i.time_value;
                end else if (q_item_i.progress < last_prog_q) begin
                  order_d = 1'b0;
                end
                res_align_d = align_ok(count_d, order_d, first_prog_d, last_prog_d);
              end
            end
            OP_QUERY: begin
              if (count_q == '0) begin
                res_time_d = q_item_i.time_value;
                res_fb_d   = 1'b1;
              end else if (q_item_i.progress <= first_prog_q) begin
                res_time_d = first_time_q;
              end else if (q_item_i.progress > last_prog_q) begin
                res_time_d = last_plus[TIME_W] ? '1 : last_plus[TIME_W-1:0];
              end else begin
                // Result is held back until the search completes.
                rsp_valid_d = 1'b0;
                p_d         = q_item_i.progress;
                lo_d        = '0;
                len_d       = count_q;
                state_d     = ST_PROBE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_PROBE: begin
        if (len_q == '0) begin
          if (lo_q == '0) begin
            res_time_d  = first_time_q;
            rsp_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end else if (lo_q >= count_q) begin
            res_time_d  = last_time_q;
            rsp_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            raddr   = lo_q[ADDR_W-1:0];
            mid_d   = lo_q;
            state_d = ST_RDLO;
          end
        end else begin
          mid_d   = mid;
          state_d = ST_CMP;
        end
      end

      ST_CMP: begin
        if (prog_rdata < p_q) begin
          lo_d  = mid_q + CNT_W'(1);
          len_d = len_q - half - CNT_W'(1);
        end else begin
          len_d = half;
        end
        state_d = ST_PROBE;
      end

      ST_RDLO: begin
        prog_hi_d = prog_rdata;
        time_hi_d = time_rdata;
        raddr     = ADDR_W'(mid_q - CNT_W'(1));
        state_d   = ST_CALC;
      end

      ST_CALC: begin
        if (prog_hi_q <= prog_rdata) begin
          res_time_d  = time_hi_q;
          rsp_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          delta_d = prog_hi_q - prog_rdata;
          if (p_q <= prog_rdata) begin
            num_d = '0;
          end else if (p_q - prog_rdata > delta_d) begin
            num_d = delta_d;
          end else begin
            num_d = p_q - prog_rdata;
          end
          t0_d    = time_rdata;
          up_d    = time_hi_q >= time_rdata;
          mag_d   = (time_hi_q >= time_rdata) ? time_hi_q - time_rdata
                                              : time_rdata - time_hi_q;
          state_d = ST_MUL;
        end
      end

      ST_MUL: begin
        prod_d  = PROD_W'(mag_q) * PROD_W'(num_q);
        state_d = ST_DIV;
      end

      ST_DIV: begin
        div_start = 1'b1;
        state_d   = ST_WAIT;
      end

      ST_WAIT: begin
        if (div_done) begin
          res_time_d  = up_q ? t0_q + div_quot : t0_q - div_quot;
          rsp_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state and result handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      order_q     <= 1'b1;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      order_q     <= order_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    first_prog_q <= first_prog_d;
    first_time_q <= first_time_d;
    last_prog_q  <= last_prog_d;
    last_time_q  <= last_time_d;
    p_q          <= p_d;
    lo_q         <= lo_d;
    len_q        <= len_d;
    mid_q        <= mid_d;
    prog_hi_q    <= prog_hi_d;
    time_hi_q    <= time_hi_d;
    t0_q         <= t0_d;
    up_q         <= up_d;
    mag_q        <= mag_d;
    num_q        <= num_d;
    delta_q      <= delta_d;
    prod_q       <= prod_d;
    res_time_q   <= res_time_d;
    res_fb_q     <= res_fb_d;
    res_align_q  <= res_align_d;
    res_drop_q   <= res_drop_d;
  end

endmodule

@@ hdl/progress_to_time_interpolator.sv @@
// Channel   Dir  Payload
// req_i     in   func, progress, time_value
// rsp_o     out  result_time, used_fallback, alignment_ok, dropped
//
// Clear, append, unused codes and queries that hit the empty, low or high
// boundary give their result in the cycle after leaving the queue. An
// interpolating query searches the frame memory, each probe passing through
// ST_PROBE and ST_CMP, then a multiply and a 56-step bit-serial divider.
// rst_ni is asynchronous, active low; it empties the table and the queue.
// A two-entry request queue keeps taking requests while a result stalls.
module progress_to_time_interpolator import ptti_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  ptti_req_if.sink   req_i,
  ptti_rsp_if.source rsp_o
);

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  ptti_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_ready_i (q_ready)
  );

  ptti_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_ready_o (q_ready),
    .rsp_o     (rsp_o)
  );

endmodule
